@@ sv/hrhp_pkg.sv @@
package hrhp_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_reply;
  } in_item_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        header_done;
    logic        reply_done;
    logic        reply_error;
    logic [9:0]  resp_status;
    logic [15:0] content_length;
  } out_item_t;

endpackage

@@ sv/hrhp_in_if.sv @@
interface hrhp_in_if;
  import hrhp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/hrhp_out_if.sv @@
interface hrhp_out_if;
  import hrhp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/hrhp_parse.sv @@
module hrhp_parse #(
  parameter int MAX_REPLY_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_i,
  input  hrhp_pkg::in_item_t  item_i,
  output hrhp_pkg::out_item_t result_o
);
  import hrhp_pkg::*;

  localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REPLY_BYTES);

  localparam logic [4:0]  STATUS_PFX_LEN = 5'd8;
  localparam logic [4:0]  LENGTH_PFX_LEN = 5'd15;
  localparam logic [4:0]  OFFSET_MAX     = 5'd31;
  localparam logic [9:0]  STATUS_MAX     = 10'd999;
  localparam logic [15:0] LENGTH_MAX     = 16'd65535;
  localparam logic [7:0]  CHR_LF         = 8'h0A;
  localparam logic [7:0]  CHR_PLUS       = 8'h2B;
  localparam logic [7:0]  CHR_H          = 8'h48;
  localparam logic [7:0]  CHR_C          = 8'h43;
  localparam logic [23:0] CRLFCR         = 24'h0D0A0D;

  localparam logic [7:0] STATUS_PFX [8] = '{"H", "T", "T", "P", "/", "1", ".", "1"};
  localparam logic [7:0] LENGTH_PFX [16] = '{"C", "o", "n", "t", "e", "n", "t", "-",
                                             "L", "e", "n", "g", "t", "h", ":", 8'h00};

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER     = 2'd0,
    KIND_STATUS    = 2'd1,
    KIND_LENGTH    = 2'd2,
    KIND_UNDECIDED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    NUM_START  = 2'd0,
    NUM_GAP    = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_END    = 2'd3
  } num_stage_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  phase_t           phase_r, phase_nxt, phase_c;
  logic [4:0]       off_r, off_nxt, off_c;
  kind_t            kind_r, kind_nxt, kind_c;
  logic [23:0]      last_r, last_nxt, last_c;
  logic [15:0]      acc_r, acc_nxt, acc_c;
  num_stage_t       stage_r, stage_nxt, stage_c;
  logic [9:0]       status_r, status_nxt, status_c;
  logic [15:0]      len_r, len_nxt, len_c;
  logic [CNT_W-1:0] total_r, total_nxt, total_c;
  logic [15:0]      body_cnt_r, body_cnt_nxt, body_cnt_c;
  logic             seen_r, seen_nxt, seen_c;

  logic [7:0]  b;
  logic        start;
  logic        b_digit;
  logic        b_space;
  logic [15:0] dval;
  logic [19:0] mac;
  logic [15:0] status_acc;
  logic [15:0] length_acc;
  logic        body_valid;

  assign b       = item_i.rx_byte;
  assign start   = item_i.start_reply;
  assign b_digit = is_digit(b);
  assign b_space = is_space(b);
  assign dval    = {12'd0, b[3:0]};

  // clear before this byte when a new reply begins
  assign phase_c    = start ? PH_HEADER : phase_r;
  assign off_c      = start ? 5'd0 : off_r;
  assign kind_c     = start ? KIND_UNDECIDED : kind_r;
  assign last_c     = start ? 24'd0 : last_r;
  assign acc_c      = start ? 16'd0 : acc_r;
  assign stage_c    = start ? NUM_START : stage_r;
  assign status_c   = start ? 10'd0 : status_r;
  assign len_c      = start ? 16'd0 : len_r;
  assign total_c    = start ? '0 : total_r;
  assign body_cnt_c = start ? 16'd0 : body_cnt_r;
  assign seen_c     = start ? 1'b0 : seen_r;

  // acc * 10 + digit
  assign mac = ({4'd0, acc_c} << 3) + ({4'd0, acc_c} << 1) + {16'd0, b[3:0]};
  assign status_acc = (mac > {10'd0, STATUS_MAX}) ? {6'd0, STATUS_MAX} : mac[15:0];
  assign length_acc = (mac > {4'd0, LENGTH_MAX}) ? LENGTH_MAX : mac[15:0];

  always_comb begin
    phase_nxt    = phase_c;
    off_nxt      = off_c;
    kind_nxt     = kind_c;
    last_nxt     = last_c;
    acc_nxt      = acc_c;
    stage_nxt    = stage_c;
    status_nxt   = status_c;
    len_nxt      = len_c;
    total_nxt    = total_c;
    body_cnt_nxt = body_cnt_c;
    seen_nxt     = seen_c;
    body_valid   = 1'b0;

    unique case (phase_c)
      PH_HEADER: begin
        total_nxt = total_c + CNT_W'(1);
        if (b == CHR_LF) begin
          if (last_c == CRLFCR) begin
            seen_nxt  = 1'b1;
            phase_nxt = (len_c == 16'd0) ? PH_DONE : PH_BODY;
          end else begin
            if ((kind_c == KIND_STATUS) && (off_c >= STATUS_PFX_LEN)) begin
              if (stage_c == NUM_DIGITS) begin
                status_nxt = acc_c[9:0];
              end
            end else if ((kind_c == KIND_LENGTH) && (off_c >= LENGTH_PFX_LEN)) begin
              if (stage_c == NUM_DIGITS) begin
                len_nxt = acc_c;
              end else if (stage_c != NUM_END) begin
                len_nxt = 16'd0;
              end
            end
            off_nxt   = 5'd0;
            kind_nxt  = KIND_UNDECIDED;
            stage_nxt = NUM_START;
            acc_nxt   = 16'd0;
          end
        end else begin
          if (off_c == 5'd0) begin
            kind_nxt  = (b == CHR_H) ? KIND_STATUS : (b == CHR_C) ? KIND_LENGTH : KIND_OTHER;
            stage_nxt = NUM_START;
            acc_nxt   = 16'd0;
          end else if (kind_c == KIND_STATUS) begin
            if (off_c < STATUS_PFX_LEN) begin
              if (b != STATUS_PFX[off_c[2:0]]) begin
                kind_nxt = KIND_OTHER;
              end
            end else begin
              unique case (stage_c)
                NUM_START: begin
                  if (b_space) begin
                    stage_nxt = NUM_GAP;
                  end
                end
                NUM_GAP: begin
                  if (b_digit) begin
                    acc_nxt   = dval;
                    stage_nxt = NUM_DIGITS;
                  end else if (!b_space) begin
                    stage_nxt = NUM_END;
                  end
                end
                NUM_DIGITS: begin
                  if (b_digit) begin
                    acc_nxt = status_acc;
                  end else begin
                    status_nxt = acc_c[9:0];
                    stage_nxt  = NUM_END;
                  end
                end
                NUM_END: begin
                end
              endcase
            end
          end else if (kind_c == KIND_LENGTH) begin
            if (off_c < LENGTH_PFX_LEN) begin
              if (b != LENGTH_PFX[off_c[3:0]]) begin
                kind_nxt = KIND_OTHER;
              end
            end else if (off_c > LENGTH_PFX_LEN) begin
              unique case (stage_c)
                NUM_START: begin
                  if (b_digit) begin
                    acc_nxt   = dval;
                    stage_nxt = NUM_DIGITS;
                  end else if (b == CHR_PLUS) begin
                    stage_nxt = NUM_GAP;
                  end else if (!b_space) begin
                    len_nxt   = 16'd0;
                    stage_nxt = NUM_END;
                  end
                end
                NUM_GAP: begin
                  if (b_digit) begin
                    acc_nxt   = dval;
                    stage_nxt = NUM_DIGITS;
                  end else begin
                    len_nxt   = 16'd0;
                    stage_nxt = NUM_END;
                  end
                end
                NUM_DIGITS: begin
                  if (b_digit) begin
                    acc_nxt = length_acc;
                  end else begin
                    len_nxt   = acc_c;
                    stage_nxt = NUM_END;
                  end
                end
                NUM_END: begin
                end
              endcase
            end
          end
          if (off_c != OFFSET_MAX) begin
            off_nxt = off_c + 5'd1;
          end
        end
        last_nxt = {last_c[15:0], b};
        if ((phase_nxt != PH_DONE) && (total_nxt >= MAX_CNT)) begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_BODY: begin
        total_nxt    = total_c + CNT_W'(1);
        body_valid   = 1'b1;
        body_cnt_nxt = body_cnt_c + 16'd1;
        if (body_cnt_nxt >= len_c) begin
          phase_nxt = PH_DONE;
        end else if (total_nxt >= MAX_CNT) begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_DONE, PH_ERROR: begin
      end
    endcase
  end

  always_comb begin
    result_o.body_valid     = body_valid;
    result_o.body_byte      = body_valid ? b : 8'd0;
    result_o.header_done    = seen_nxt;
    result_o.reply_done     = (phase_nxt == PH_DONE);
    result_o.reply_error    = (phase_nxt == PH_ERROR);
    result_o.resp_status    = status_nxt;
    result_o.content_length = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      off_r      <= 5'd0;
      kind_r     <= KIND_UNDECIDED;
      last_r     <= 24'd0;
      acc_r      <= 16'd0;
      stage_r    <= NUM_START;
      status_r   <= 10'd0;
      len_r      <= 16'd0;
      total_r    <= '0;
      body_cnt_r <= 16'd0;
      seen_r     <= 1'b0;
    end else if (step_i) begin
      phase_r    <= phase_nxt;
      off_r      <= off_nxt;
      kind_r     <= kind_nxt;
      last_r     <= last_nxt;
      acc_r      <= acc_nxt;
      stage_r    <= stage_nxt;
      status_r   <= status_nxt;
      len_r      <= len_nxt;
      total_r    <= total_nxt;
      body_cnt_r <= body_cnt_nxt;
      seen_r     <= seen_nxt;
    end
  end

`ifndef SYNTH
  a_body_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_cnt_r < len_r))
    else $error("body count reached declared length while still in body");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MAX_CNT)
    else $error("byte count ran past the limit");

  a_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && !start && ((phase_r == PH_DONE) || (phase_r == PH_ERROR)))
      |=> (phase_r == $past(phase_r)))
    else $error("finished reply left its end phase without a restart");

  a_body_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && result_o.body_valid) |-> result_o.header_done)
    else $error("body item before end of header");

  a_done_xor_error: assert property (@(posedge clk) disable iff (!rst_n)
    step_i |-> !(result_o.reply_done && result_o.reply_error))
    else $error("done and error raised together");
`endif

endmodule

@@ sv/http_reply_header_parser.sv @@
// Parses a received HTTP reply one byte per item and returns one result item per input
// item: the body byte when it belongs to the declared body, the header and completion
// flags, the status code and the declared content length. A new byte is accepted on every
// clock while the input register is empty or its item can move on; each item passes
// through the input register, then the result register, and the whole parser state is
// updated when the item moves from the first into the second. A stalled result holds the
// input register, and the input stalls only when both registers are full.
// Setting start_reply on a byte clears the parser before that byte is used. Once the reply
// is done or has hit MAX_REPLY_BYTES, further bytes still yield results, with all flags
// and values held.
module http_reply_header_parser #(
  parameter int MAX_REPLY_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  hrhp_in_if.sink           in_chan,
  hrhp_out_if.source        out_chan
);
  import hrhp_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t result;
  logic      out_free;
  logic      step;
  logic      in_acc;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign step          = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  hrhp_parse #(
    .MAX_REPLY_BYTES (MAX_REPLY_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .item_i   (s1_data_r),
    .result_o (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_chan.data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`ifndef SYNTH
  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed item did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !step)
    else $error("result overwritten while stalled");

  a_no_input_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step) |-> !in_acc)
    else $error("input register overwritten before use");
`endif

endmodule
